// File: sv/apnn_pkg.sv
// Shared types and constants for the all-pairs nearest neighbor block.
package apnn_pkg;

	// Configuration port
	localparam int CFG_BITS = 7;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_SAMPLES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_FEATURES = 2'd1;

	// Result fields
	localparam int OUT_IDX_BITS = 6;
	localparam int DIST_BITS = 22;
	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
	localparam int OUT_DATA_W = 40;

	// Control that travels with each scanned feature value down the chain
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} scan_ctl_t;

	// Control of the result shift chain
	typedef struct packed {
		logic capture;
		logic shift;
	} res_ctl_t;

endpackage

// File: sv/apnn_feeder.sv
// Sample store and scan sequencer that feeds reference features into the cell chain.
module apnn_feeder #(
	parameter int MAX_SAMPLES = 64,
	parameter int MAX_FEATURES = 64,
	parameter int FEATURE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [$clog2(MAX_SAMPLES)-1:0] wr_sample,
	input  logic [((MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1)-1:0] wr_feat,
	input  logic [FEATURE_BITS-1:0] wr_data,
	input  logic start,
	input  logic [$clog2(MAX_SAMPLES+1)-1:0] ns,
	input  logic [$clog2(MAX_FEATURES+1)-1:0] nf,
	output logic done,
	output apnn_pkg::scan_ctl_t ctl_out,
	output logic [$clog2(MAX_SAMPLES)-1:0] j_out,
	output logic [((MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1)-1:0] k_out,
	output logic [FEATURE_BITS-1:0] v_out
);

	localparam int SIDX_W = $clog2(MAX_SAMPLES);
	localparam int FIDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int DEPTH = MAX_SAMPLES * (2 ** FIDX_W);

	logic [FEATURE_BITS-1:0] mem [DEPTH];
	logic busy_q;
	logic [SIDX_W-1:0] j_q;
	logic [FIDX_W-1:0] k_q;
	logic k_last;
	logic j_last;
	apnn_pkg::scan_ctl_t ctl_s1;
	logic [SIDX_W-1:0] j_s1;
	logic [FIDX_W-1:0] k_s1;
	logic [FEATURE_BITS-1:0] v_s1;

	assign k_last = (int'(k_q) + 1 >= int'(nf));
	assign j_last = (int'(j_q) + 1 >= int'(ns));
	assign done = busy_q && k_last && j_last;

	// Step through reference sample j, feature k
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			j_q <= '0;
			k_q <= '0;
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= busy_q;
			ctl_s1.first <= (k_q == '0);
			ctl_s1.last <= k_last;
			if (start) begin
				busy_q <= 1'b1;
				j_q <= '0;
				k_q <= '0;
			end else if (busy_q) begin
				if (k_last) begin
					k_q <= '0;
					if (j_last) begin
						busy_q <= 1'b0;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
		end
	end

	// Write loaded values, read the scanned value
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[{wr_sample, wr_feat}] <= wr_data;
		end
		v_s1 <= mem[{j_q, k_q}];
		j_s1 <= j_q;
		k_s1 <= k_q;
	end

	assign ctl_out = ctl_s1;
	assign j_out = j_s1;
	assign k_out = k_s1;
	assign v_out = v_s1;

endmodule

// File: sv/apnn_cell.sv
// One chain cell: holds one sample, accumulates L1 distances and keeps the best neighbor.
module apnn_cell #(
	parameter int MAX_SAMPLES = 64,
	parameter int MAX_FEATURES = 64,
	parameter int FEATURE_BITS = 16,
	parameter int INDEX = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [$clog2(MAX_SAMPLES)-1:0] wr_sample,
	input  logic [((MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1)-1:0] wr_feat,
	input  logic [FEATURE_BITS-1:0] wr_data,
	input  apnn_pkg::scan_ctl_t ctl_in,
	input  logic [$clog2(MAX_SAMPLES)-1:0] j_in,
	input  logic [((MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1)-1:0] k_in,
	input  logic [FEATURE_BITS-1:0] v_in,
	output apnn_pkg::scan_ctl_t ctl_out,
	output logic [$clog2(MAX_SAMPLES)-1:0] j_out,
	output logic [((MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1)-1:0] k_out,
	output logic [FEATURE_BITS-1:0] v_out,
	input  apnn_pkg::res_ctl_t res_ctl,
	input  logic [$clog2(MAX_SAMPLES)-1:0] res_nbr_in,
	input  logic [apnn_pkg::DIST_BITS-1:0] res_dist_in,
	input  logic res_none_in,
	output logic [$clog2(MAX_SAMPLES)-1:0] res_nbr_out,
	output logic [apnn_pkg::DIST_BITS-1:0] res_dist_out,
	output logic res_none_out
);

	localparam int SIDX_W = $clog2(MAX_SAMPLES);
	localparam int FIDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int SUM_W = FEATURE_BITS + 1 + FIDX_W;
	localparam int CMP_W = (SUM_W > apnn_pkg::DIST_BITS) ? SUM_W : apnn_pkg::DIST_BITS;
	localparam logic [SIDX_W-1:0] MY_IDX = SIDX_W'(INDEX);

	logic [FEATURE_BITS-1:0] mem [MAX_FEATURES];
	apnn_pkg::scan_ctl_t ctl_s1;
	logic [SIDX_W-1:0] j_s1;
	logic [FIDX_W-1:0] k_s1;
	logic [FEATURE_BITS-1:0] v_s1;
	logic [FEATURE_BITS-1:0] own_s1;
	logic [SUM_W-1:0] acc_q;
	logic [SUM_W-1:0] best_q;
	logic [SIDX_W-1:0] bidx_q;
	logic found_q;
	logic [SIDX_W-1:0] res_nbr_q;
	logic [apnn_pkg::DIST_BITS-1:0] res_dist_q;
	logic res_none_q;
	logic signed [FEATURE_BITS:0] diff;
	logic [FEATURE_BITS:0] absd;
	logic [SUM_W-1:0] sum;
	logic found_eff;
	logic take;
	logic [CMP_W-1:0] best_ext;
	logic [apnn_pkg::DIST_BITS-1:0] best_sat;

	// Keep this cell's sample and read the feature matching the passing value
	always_ff @(posedge clk) begin
		if (wr_en && wr_sample == MY_IDX) begin
			mem[wr_feat] <= wr_data;
		end
		own_s1 <= mem[k_in];
		j_s1 <= j_in;
		k_s1 <= k_in;
		v_s1 <= v_in;
	end

	// Absolute difference and running sum for the current pair
	always_comb begin
		diff = $signed({v_s1[FEATURE_BITS-1], v_s1}) - $signed({own_s1[FEATURE_BITS-1], own_s1});
		absd = diff[FEATURE_BITS] ? (FEATURE_BITS+1)'(-diff) : $unsigned(diff);
		sum = (ctl_s1.first ? '0 : acc_q) + SUM_W'(absd);
		found_eff = found_q && !(ctl_s1.first && j_s1 == '0);
		take = ctl_s1.valid && ctl_s1.last && (j_s1 != MY_IDX) && (!found_eff || sum < best_q);
		best_ext = CMP_W'(best_q);
		best_sat = (best_ext > CMP_W'(apnn_pkg::DIST_MAX)) ? apnn_pkg::DIST_MAX
			: apnn_pkg::DIST_BITS'(best_ext);
	end

	// Hold scan control and the found flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			found_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl_in;
			if (ctl_s1.valid) begin
				found_q <= found_eff || take;
			end
		end
	end

	// Accumulate and keep the best candidate; capture or shift results
	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			acc_q <= sum;
		end
		if (take) begin
			best_q <= sum;
			bidx_q <= j_s1;
		end
		if (res_ctl.capture) begin
			res_none_q <= !found_q;
			res_nbr_q <= found_q ? bidx_q : '0;
			res_dist_q <= found_q ? best_sat : apnn_pkg::DIST_MAX;
		end else if (res_ctl.shift) begin
			res_none_q <= res_none_in;
			res_nbr_q <= res_nbr_in;
			res_dist_q <= res_dist_in;
		end
	end

	assign ctl_out = ctl_s1;
	assign j_out = j_s1;
	assign k_out = k_s1;
	assign v_out = v_s1;
	assign res_nbr_out = res_nbr_q;
	assign res_dist_out = res_dist_q;
	assign res_none_out = res_none_q;

endmodule

// File: sv/all_pairs_nearest_neighbor_l1.sv
// Top level of the all-pairs L1 nearest neighbor search: loader, cell chain and result output.
//
//  channel | signals                         | request
//  --------+---------------------------------+-------------------------------------------
//  cfg     | cfg_valid cfg_ready cfg_index   | write num_samples (0) or num_features (1)
//          | cfg_data                        |
//  s       | s_tvalid s_tready s_tdata       | one feature value, sample after sample
//  m       | m_tvalid m_tready m_tdata       | one nearest neighbor result per sample
//          | m_tuser m_tlast                 |
//
// Loading writes each accepted feature value into the stores. After the final value the scan streams all
// ns*nf stored values through the chain of MAX_SAMPLES cells at one value per cycle, then
// waits for the chain to drain; the single store read port sets that rate.
// Results then leave one per cycle unless m_tready stalls; the next set loads while they drain.
// Reset clears the load counters and registers num_samples and num_features to 64.
// s_tready is low during scan and flush; flush ends only once the previous set's results
// have all left, so a stalled m channel stalls the input after the next set has loaded.
module all_pairs_nearest_neighbor_l1 #(
	parameter int MAX_SAMPLES = 64,
	parameter int MAX_FEATURES = 64,
	parameter int FEATURE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [apnn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [apnn_pkg::CFG_BITS-1:0] cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	// s_tdata: feature_value, zero padding
	input  logic [((FEATURE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// m_tdata: sample_index[5:0], neighbor_index[11:6], distance[33:12], zero padding
	output logic [apnn_pkg::OUT_DATA_W-1:0] m_tdata,
	// m_tuser: no_neighbor
	output logic m_tuser,
	output logic m_tlast
);

	localparam int SIDX_W = $clog2(MAX_SAMPLES);
	localparam int FIDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int NS_W = $clog2(MAX_SAMPLES + 1);
	localparam int NF_W = $clog2(MAX_FEATURES + 1);
	localparam int FLUSH_CYC = MAX_SAMPLES + 3;
	localparam int FL_W = $clog2(FLUSH_CYC + 1);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_FEED,
		ST_FLUSH
	} state_t;

	state_t state_q;
	logic [apnn_pkg::CFG_BITS-1:0] ns_reg_q;
	logic [apnn_pkg::CFG_BITS-1:0] nf_reg_q;
	logic [NS_W-1:0] ns_eff;
	logic [NF_W-1:0] nf_eff;
	logic [SIDX_W-1:0] load_s_q;
	logic [FIDX_W-1:0] load_f_q;
	logic [FL_W-1:0] flush_q;
	logic [NS_W-1:0] drain_left_q;
	logic [SIDX_W-1:0] out_idx_q;
	logic m_tvalid_q;
	logic [apnn_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic m_tuser_q;
	logic m_tlast_q;
	logic in_acc;
	logic cfg_acc;
	logic f_last;
	logic s_last;
	logic start;
	logic done;
	logic capture;
	logic out_load;
	apnn_pkg::res_ctl_t res_ctl;

	apnn_pkg::scan_ctl_t ch_ctl [MAX_SAMPLES+1];
	logic [SIDX_W-1:0] ch_j [MAX_SAMPLES+1];
	logic [FIDX_W-1:0] ch_k [MAX_SAMPLES+1];
	logic [FEATURE_BITS-1:0] ch_v [MAX_SAMPLES+1];
	logic [SIDX_W-1:0] res_nbr [MAX_SAMPLES+1];
	logic [apnn_pkg::DIST_BITS-1:0] res_dist [MAX_SAMPLES+1];
	logic res_none [MAX_SAMPLES+1];

	// Clamp the count registers to their legal range
	always_comb begin
		if (ns_reg_q == '0) begin
			ns_eff = NS_W'(1);
		end else if (int'(ns_reg_q) > MAX_SAMPLES) begin
			ns_eff = NS_W'(MAX_SAMPLES);
		end else begin
			ns_eff = NS_W'(ns_reg_q);
		end
		if (nf_reg_q == '0) begin
			nf_eff = NF_W'(1);
		end else if (int'(nf_reg_q) > MAX_FEATURES) begin
			nf_eff = NF_W'(MAX_FEATURES);
		end else begin
			nf_eff = NF_W'(nf_reg_q);
		end
	end

	assign cfg_ready = 1'b1;
	assign cfg_acc = cfg_valid && cfg_ready;
	assign s_tready = (state_q == ST_LOAD);
	assign in_acc = s_tvalid && s_tready;
	assign f_last = (int'(load_f_q) + 1 >= int'(nf_eff));
	assign s_last = (int'(load_s_q) + 1 >= int'(ns_eff));
	assign start = in_acc && f_last && s_last;
	assign capture = (state_q == ST_FLUSH) && (flush_q == '0) && (drain_left_q == '0);
	assign out_load = (drain_left_q != '0) && (!m_tvalid_q || m_tready);
	assign res_ctl.capture = capture;
	assign res_ctl.shift = out_load;

	// Load counters, registers and sequencing of load, scan and flush
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			ns_reg_q <= apnn_pkg::CFG_BITS'(64);
			nf_reg_q <= apnn_pkg::CFG_BITS'(64);
			load_s_q <= '0;
			load_f_q <= '0;
			flush_q <= '0;
		end else begin
			if (cfg_acc && (cfg_index == apnn_pkg::REG_NUM_SAMPLES
				|| cfg_index == apnn_pkg::REG_NUM_FEATURES)) begin
				if (cfg_index == apnn_pkg::REG_NUM_SAMPLES) begin
					ns_reg_q <= cfg_data;
				end else begin
					nf_reg_q <= cfg_data;
				end
				load_s_q <= '0;
				load_f_q <= '0;
			end else if (in_acc) begin
				if (f_last) begin
					load_f_q <= '0;
					load_s_q <= s_last ? '0 : load_s_q + 1'b1;
				end else begin
					load_f_q <= load_f_q + 1'b1;
				end
			end
			unique case (state_q)
				ST_LOAD: begin
					if (start) begin
						state_q <= ST_FEED;
					end
				end
				ST_FEED: begin
					if (done) begin
						state_q <= ST_FLUSH;
						flush_q <= FL_W'(FLUSH_CYC);
					end
				end
				ST_FLUSH: begin
					if (flush_q != '0) begin
						flush_q <= flush_q - 1'b1;
					end else if (drain_left_q == '0) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Output register fed from the head of the result chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			drain_left_q <= '0;
			out_idx_q <= '0;
		end else begin
			if (capture) begin
				drain_left_q <= ns_eff;
				out_idx_q <= '0;
			end else if (out_load) begin
				drain_left_q <= drain_left_q - 1'b1;
				out_idx_q <= out_idx_q + 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= apnn_pkg::OUT_DATA_W'({res_dist[0],
				apnn_pkg::OUT_IDX_BITS'(res_nbr[0]),
				apnn_pkg::OUT_IDX_BITS'(out_idx_q)});
			m_tuser_q <= res_none[0];
			m_tlast_q <= (drain_left_q == NS_W'(1));
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;
	assign m_tlast = m_tlast_q;

	apnn_feeder #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.MAX_FEATURES(MAX_FEATURES),
		.FEATURE_BITS(FEATURE_BITS)
	) u_feeder (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (in_acc),
		.wr_sample(load_s_q),
		.wr_feat  (load_f_q),
		.wr_data  (s_tdata[FEATURE_BITS-1:0]),
		.start    (start),
		.ns       (ns_eff),
		.nf       (nf_eff),
		.done     (done),
		.ctl_out  (ch_ctl[0]),
		.j_out    (ch_j[0]),
		.k_out    (ch_k[0]),
		.v_out    (ch_v[0])
	);

	// Tail of the result chain shifts in nothing
	assign res_nbr[MAX_SAMPLES] = '0;
	assign res_dist[MAX_SAMPLES] = '0;
	assign res_none[MAX_SAMPLES] = 1'b0;

	for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
		apnn_cell #(
			.MAX_SAMPLES (MAX_SAMPLES),
			.MAX_FEATURES(MAX_FEATURES),
			.FEATURE_BITS(FEATURE_BITS),
			.INDEX       (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.wr_en       (in_acc),
			.wr_sample   (load_s_q),
			.wr_feat     (load_f_q),
			.wr_data     (s_tdata[FEATURE_BITS-1:0]),
			.ctl_in      (ch_ctl[i]),
			.j_in        (ch_j[i]),
			.k_in        (ch_k[i]),
			.v_in        (ch_v[i]),
			.ctl_out     (ch_ctl[i+1]),
			.j_out       (ch_j[i+1]),
			.k_out       (ch_k[i+1]),
			.v_out       (ch_v[i+1]),
			.res_ctl     (res_ctl),
			.res_nbr_in  (res_nbr[i+1]),
			.res_dist_in (res_dist[i+1]),
			.res_none_in (res_none[i+1]),
			.res_nbr_out (res_nbr[i]),
			.res_dist_out(res_dist[i]),
			.res_none_out(res_none[i])
		);
	end

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the all-pairs L1 nearest neighbor block.
module tb_top;

	localparam int MAX_SAMPLES = 64;
	localparam int MAX_FEATURES = 64;
	localparam int FEATURE_BITS = 16;
	localparam int SETTLE_CYCLES = MAX_SAMPLES + 16;
	localparam int HOLD_CYCLES = 400;
	localparam int PAD_LSB = 2 * apnn_pkg::OUT_IDX_BITS + apnn_pkg::DIST_BITS;
	localparam logic [apnn_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd2;

	typedef struct packed {
		logic [apnn_pkg::OUT_IDX_BITS-1:0] sample_index;
		logic [apnn_pkg::OUT_IDX_BITS-1:0] neighbor_index;
		logic [apnn_pkg::DIST_BITS-1:0] distance;
		logic no_neighbor;
		logic last_result;
	} nn_result_t;

	// Mirror of the block: stored features, load position, count registers
	class nn_result_checker;
		int feature_mem [MAX_SAMPLES][MAX_FEATURES];
		int load_sample = 0;
		int load_feature = 0;
		logic [apnn_pkg::CFG_BITS-1:0] reg_samples = 7'd64;
		logic [apnn_pkg::CFG_BITS-1:0] reg_features = 7'd64;
		nn_result_t pending_results[$];
		int errors = 0;

		function int clamp_count(logic [apnn_pkg::CFG_BITS-1:0] raw, int limit);
			if (raw == 0)
				return 1;
			if (raw > limit)
				return limit;
			return int'(raw);
		endfunction

		function void apply_reg(logic [apnn_pkg::CFG_IDX_W-1:0] idx,
			logic [apnn_pkg::CFG_BITS-1:0] val);
			if (idx == apnn_pkg::REG_NUM_SAMPLES)
				reg_samples = val;
			else if (idx == apnn_pkg::REG_NUM_FEATURES)
				reg_features = val;
			else
				return;
			// abandon any partial load
			load_sample = 0;
			load_feature = 0;
		endfunction

		// Store one accepted feature; on the final value of a set, predict every result
		function void note_feature(logic [FEATURE_BITS-1:0] raw);
			int ns;
			int nf;
			int sum;
			int diff;
			int best;
			int best_idx;
			bit found;
			nn_result_t r;
			ns = clamp_count(reg_samples, MAX_SAMPLES);
			nf = clamp_count(reg_features, MAX_FEATURES);
			feature_mem[load_sample][load_feature] = int'($signed(raw));
			if (load_feature + 1 < nf) begin
				load_feature++;
				return;
			end
			load_feature = 0;
			if (load_sample + 1 < ns) begin
				load_sample++;
				return;
			end
			load_sample = 0;
			for (int i = 0; i < ns; i++) begin
				found = 0;
				best = 0;
				best_idx = 0;
				for (int j = 0; j < ns; j++) begin
					if (j == i)
						continue;
					sum = 0;
					for (int k = 0; k < nf; k++) begin
						diff = feature_mem[i][k] - feature_mem[j][k];
						sum += (diff < 0) ? -diff : diff;
					end
					// strict compare keeps the lowest index on ties
					if (!found || sum < best) begin
						found = 1;
						best = sum;
						best_idx = j;
					end
				end
				r.sample_index = i[apnn_pkg::OUT_IDX_BITS-1:0];
				if (found) begin
					r.neighbor_index = best_idx[apnn_pkg::OUT_IDX_BITS-1:0];
					r.distance = (best > int'(apnn_pkg::DIST_MAX)) ? apnn_pkg::DIST_MAX
						: best[apnn_pkg::DIST_BITS-1:0];
					r.no_neighbor = 1'b0;
				end else begin
					r.neighbor_index = '0;
					r.distance = apnn_pkg::DIST_MAX;
					r.no_neighbor = 1'b1;
				end
				r.last_result = (i + 1 == ns);
				pending_results.push_back(r);
			end
		endfunction

		function void check_field(string name, int unsigned exp_val, int unsigned act_val);
			if (exp_val != act_val) begin
				$error("%s: expected %0d, got %0d", name, exp_val, act_val);
				errors++;
			end
		endfunction

		// Compare one accepted result with the oldest prediction
		function void check_result(logic [apnn_pkg::OUT_DATA_W-1:0] data, logic user,
			logic last);
			nn_result_t r;
			if (pending_results.size() == 0) begin
				$error("unexpected result: sample_index %0d",
					data[apnn_pkg::OUT_IDX_BITS-1:0]);
				errors++;
				return;
			end
			r = pending_results.pop_front();
			check_field("sample_index", r.sample_index, data[apnn_pkg::OUT_IDX_BITS-1:0]);
			check_field("neighbor_index", r.neighbor_index,
				data[2*apnn_pkg::OUT_IDX_BITS-1:apnn_pkg::OUT_IDX_BITS]);
			check_field("distance", r.distance, data[PAD_LSB-1:2*apnn_pkg::OUT_IDX_BITS]);
			check_field("tdata padding", 0, data[apnn_pkg::OUT_DATA_W-1:PAD_LSB]);
			check_field("no_neighbor", r.no_neighbor, user);
			check_field("last_result", r.last_result, last);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [apnn_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [apnn_pkg::CFG_BITS-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [FEATURE_BITS-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [apnn_pkg::OUT_DATA_W-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;

	logic no_idle = 1'b0;
	logic hold_armed = 1'b0;
	int hold_count = 0;

	nn_result_checker checker_h = new();

	all_pairs_nearest_neighbor_l1 #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.MAX_FEATURES(MAX_FEATURES),
		.FEATURE_BITS(FEATURE_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: check accepted requests, stall at random, hold off once for a long stretch
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			checker_h.check_result(m_tdata, m_tuser, m_tlast);
		if (hold_armed && hold_count < HOLD_CYCLES) begin
			hold_count <= hold_count + 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= no_idle || ($urandom_range(0, 99) >= 33);
		end
	end

	// Mix of full-range, near-zero (many ties) and extreme values
	function automatic logic [FEATURE_BITS-1:0] rand_feature();
		case ($urandom_range(0, 9))
			0, 1: begin
				case ($urandom_range(0, 3))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'h0000;
					default: return 16'hFFFF;
				endcase
			end
			2, 3, 4: return FEATURE_BITS'($urandom_range(0, 8) - 4);
			default: return FEATURE_BITS'($urandom_range(0, 65535));
		endcase
	endfunction

	// Issue one register write request, then drop valid for a cycle
	task automatic write_reg(input logic [apnn_pkg::CFG_IDX_W-1:0] idx,
		input logic [apnn_pkg::CFG_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		checker_h.apply_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one feature request after an optional random gap; valid stays high on return
	task automatic send_feature(input logic [FEATURE_BITS-1:0] val);
		while (!no_idle && $urandom_range(0, 99) < 33) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= val;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		checker_h.note_feature(val);
	endtask

	task automatic send_random(input int count);
		for (int n = 0; n < count; n++)
			send_feature(rand_feature());
	endtask

	// Drain all predicted results, then let the block go quiet before the next write
	task automatic settle();
		s_tvalid <= 1'b0;
		while (checker_h.pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int ns;
		int nf;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single sample, zero count treated as one: every value is its own set
		write_reg(apnn_pkg::REG_NUM_SAMPLES, 7'd0);
		write_reg(apnn_pkg::REG_NUM_FEATURES, 7'd1);
		send_feature(16'h7FFF);
		send_feature(16'h8000);
		send_feature(16'h0000);
		send_feature(16'hFFFF);
		settle();

		// Two samples at opposite extremes
		write_reg(apnn_pkg::REG_NUM_SAMPLES, 7'd2);
		send_feature(16'h8000);
		send_feature(16'h7FFF);
		settle();

		// Tie: sample 0 is equally close to samples 1 and 2
		write_reg(apnn_pkg::REG_NUM_SAMPLES, 7'd3);
		write_reg(apnn_pkg::REG_NUM_FEATURES, 7'd2);
		send_feature(16'd0);
		send_feature(16'd0);
		send_feature(16'd1);
		send_feature(16'd0);
		send_feature(16'd0);
		send_feature(16'd1);

		// Partial load dropped by a register write, then a full set
		send_feature(16'h1234);
		send_feature(16'hFEDC);
		send_feature(16'h0042);
		settle();
		write_reg(apnn_pkg::REG_NUM_FEATURES, 7'd2);
		send_feature(16'd5);
		send_feature(-16'sd5);
		send_feature(16'd5);
		send_feature(-16'sd5);
		send_feature(16'h8000);
		send_feature(16'h7FFF);
		settle();

		// Write to an unmapped index
		write_reg(REG_UNUSED, 7'h7F);

		// Most samples from an oversized count, zero feature count, no idling on either side
		write_reg(apnn_pkg::REG_NUM_SAMPLES, 7'd127);
		write_reg(apnn_pkg::REG_NUM_FEATURES, 7'd0);
		no_idle <= 1'b1;
		send_random(64);
		settle();
		no_idle <= 1'b0;

		// Most features from an oversized count, with the largest possible distance
		write_reg(apnn_pkg::REG_NUM_SAMPLES, 7'd2);
		write_reg(apnn_pkg::REG_NUM_FEATURES, 7'd127);
		repeat (64)
			send_feature(16'h8000);
		repeat (64)
			send_feature(16'h7FFF);
		settle();

		// Small random sets; the first runs under a long receiver hold, the last ends
		// in an abandoned partial load when a set holds more than one value
		for (int p = 0; p < 3; p++) begin
			ns = (p == 0) ? 2 : $urandom_range(1, 4);
			nf = (p == 0) ? 1 : $urandom_range(1, 3);
			write_reg(apnn_pkg::REG_NUM_SAMPLES, ns[apnn_pkg::CFG_BITS-1:0]);
			write_reg(apnn_pkg::REG_NUM_FEATURES, nf[apnn_pkg::CFG_BITS-1:0]);
			if (p == 0)
				hold_armed <= 1'b1;
			send_random((p == 0) ? 3 * ns * nf : ns * nf);
			if (p == 2 && ns * nf > 1)
				send_random($urandom_range(1, ns * nf - 1));
			settle();
		end

		if (checker_h.errors == 0 && checker_h.pending_results.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	initial begin : watchdog
		#3000000;
		$display("tb_top: errors");
		$finish;
	end

endmodule
